// ===== design/erc_pkg.sv =====
package erc_pkg;

   // Store geometry.
   localparam int STORE_DEPTH = 1024;
   localparam int AW          = 10;
   localparam int CW          = 11;

   // Event layout.
   localparam int HDR_LEN     = 16;
   localparam int HDR_BYTES   = 17;
   localparam int LEN_OFFSET  = 12;
   localparam int MAX_PAYLOAD = 1008;

   localparam logic [31:0] EVENT_TYPE     = 32'h003f0012;
   localparam logic [15:0] HOST_TARGET    = 16'h0200;
   localparam logic [15:0] CHASSIS_MODULE = 16'h0300;
   localparam logic [15:0] DROP_CODE_A    = 16'hc205;
   localparam logic [15:0] DROP_CODE_B    = 16'hc209;
   localparam logic [31:0] LEASE_AHEAD    = 32'd3;

   // Operation codes.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // Requests from the channel logic to the engine.
   typedef struct packed {
      logic          push_we;
      logic [AW-1:0] push_addr;
      logic [7:0]    push_data;
      logic          start;
      logic          try_filter;
      logic [CW-1:0] n;
      logic [CW-1:0] len;
      logic [7:0]    count;
      logic [AW-1:0] pull_addr;
   } erc_cmd_type;

   // Completion report from the engine.
   typedef struct packed {
      logic          done;
      logic          rewritten;
      logic [CW-1:0] length;
   } erc_sts_type;

endpackage

// ===== design/erc_engine.sv =====
module erc_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  erc_pkg::erc_cmd_type cmd,
   output erc_pkg::erc_sts_type sts,
   output logic [7:0]           pull_data
);

   typedef enum logic [4:0] {
      E_IDLE, E_COPY_RD, E_COPY_WR,
      E_REC, E_ID0, E_ID1, E_CNT, E_DUP, E_D0, E_D1, E_D2,
      E_BREC, E_B0, E_B1, E_B2, E_BCODE, E_C0, E_C1, E_C2,
      E_PLEN, E_DONE
   } state_type;

   state_type state_ff;

   logic [erc_pkg::CW-1:0] k_ff, end_ff, n_ff, len_ff, at_ff, prior_ff, out_ff;
   logic [erc_pkg::AW-1:0] cidx_ff;
   logic [7:0]  count_ff, i_ff, j_ff, cnt_ff, kept_ff, lo_ff, hi_ff;
   logic [15:0] id_ff;
   logic        filt_ff;

   // Event and result stores, one read port each.
   logic [7:0] ev_mem [erc_pkg::STORE_DEPTH];
   logic [7:0] rs_mem [erc_pkg::STORE_DEPTH];
   logic [7:0] ev_rd_ff, rs_rd_ff;

   logic [erc_pkg::CW-1:0] hdr_at, hdr_prior, ev_raddr_w, out_p1, plen;
   logic [11:0] at3, at_step, prior_step;
   logic        drop;
   logic        rs_we;
   logic [erc_pkg::AW-1:0] rs_waddr;
   logic [7:0]  rs_wdata;

   // Offsets and record steps.
   assign hdr_at     = erc_pkg::CW'(erc_pkg::HDR_LEN) + at_ff;
   assign hdr_prior  = erc_pkg::CW'(erc_pkg::HDR_LEN) + prior_ff;
   assign out_p1     = out_ff + 11'd1;
   assign plen       = out_ff - erc_pkg::CW'(erc_pkg::HDR_LEN);
   assign at3        = {1'b0, at_ff} + 12'd3;
   assign at_step    = {1'b0, at_ff} + 12'd3 + {3'b000, cnt_ff, 1'b0};
   assign prior_step = {1'b0, prior_ff} + 12'd3 + {3'b000, ev_rd_ff, 1'b0};
   assign drop = (id_ff == erc_pkg::CHASSIS_MODULE) &&
                 (({ev_rd_ff, lo_ff} == erc_pkg::DROP_CODE_A) ||
                  ({ev_rd_ff, lo_ff} == erc_pkg::DROP_CODE_B));

   // Event store read address for the next cycle's data.
   always_comb begin
      case (state_ff)
         E_REC, E_BREC, E_BCODE: ev_raddr_w = hdr_at;
         E_ID0, E_B0, E_C0:      ev_raddr_w = hdr_at + 11'd1;
         E_ID1, E_B1:            ev_raddr_w = hdr_at + 11'd2;
         E_DUP:                  ev_raddr_w = hdr_prior;
         E_D0:                   ev_raddr_w = hdr_prior + 11'd1;
         E_D1:                   ev_raddr_w = hdr_prior + 11'd2;
         default:                ev_raddr_w = k_ff;
      endcase
   end

   // Result store write port.
   always_comb begin
      rs_we    = 1'b0;
      rs_waddr = k_ff[erc_pkg::AW-1:0];
      rs_wdata = ev_rd_ff;
      case (state_ff)
         E_COPY_WR: begin
            rs_we = 1'b1;
         end
         E_B0: begin
            rs_we    = 1'b1;
            rs_waddr = out_ff[erc_pkg::AW-1:0];
         end
         E_B1: begin
            rs_we    = 1'b1;
            rs_waddr = out_p1[erc_pkg::AW-1:0];
         end
         E_BCODE: begin
            rs_we    = (j_ff == cnt_ff);
            rs_waddr = cidx_ff;
            rs_wdata = kept_ff;
         end
         E_C1: begin
            rs_we    = !drop;
            rs_waddr = out_ff[erc_pkg::AW-1:0];
            rs_wdata = lo_ff;
         end
         E_C2: begin
            rs_we    = 1'b1;
            rs_waddr = out_p1[erc_pkg::AW-1:0];
            rs_wdata = hi_ff;
         end
         E_PLEN: begin
            rs_we    = 1'b1;
            rs_waddr = erc_pkg::AW'(erc_pkg::LEN_OFFSET) + {8'd0, k_ff[1:0]};
            case (k_ff[1:0])
               2'd0:    rs_wdata = plen[7:0];
               2'd1:    rs_wdata = {5'd0, plen[10:8]};
               default: rs_wdata = 8'd0;
            endcase
         end
         default: begin
            rs_we = 1'b0;
         end
      endcase
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (cmd.push_we) begin
         ev_mem[cmd.push_addr] <= cmd.push_data;
      end
      ev_rd_ff <= ev_mem[ev_raddr_w[erc_pkg::AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rs_we) begin
         rs_mem[rs_waddr] <= rs_wdata;
      end
      rs_rd_ff <= rs_mem[cmd.pull_addr];
   end

   assign pull_data = rs_rd_ff;

   // Sequencer: record check, duplicate scan, copy and filtered build.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         case (state_ff)
            E_IDLE: begin
               if (cmd.start) begin
                  n_ff     <= cmd.n;
                  len_ff   <= cmd.len;
                  count_ff <= cmd.count;
                  i_ff     <= 8'd0;
                  at_ff    <= 11'd1;
                  k_ff     <= '0;
                  filt_ff  <= 1'b0;
                  end_ff   <= cmd.n;
                  state_ff <= cmd.try_filter ? E_REC : E_COPY_RD;
               end
            end
            E_COPY_RD: begin
               if (k_ff == end_ff) begin
                  i_ff     <= 8'd0;
                  at_ff    <= 11'd1;
                  out_ff   <= erc_pkg::CW'(erc_pkg::HDR_BYTES);
                  state_ff <= filt_ff ? E_BREC : E_DONE;
               end else begin
                  state_ff <= E_COPY_WR;
               end
            end
            E_COPY_WR: begin
               k_ff     <= k_ff + 11'd1;
               state_ff <= E_COPY_RD;
            end
            E_REC: begin
               if (i_ff == count_ff) begin
                  k_ff     <= '0;
                  filt_ff  <= (at_ff == len_ff);
                  end_ff   <= (at_ff == len_ff) ? erc_pkg::CW'(erc_pkg::HDR_BYTES) : n_ff;
                  state_ff <= E_COPY_RD;
               end else if (at3 > {1'b0, len_ff}) begin
                  k_ff     <= '0;
                  state_ff <= E_COPY_RD;
               end else begin
                  state_ff <= E_ID0;
               end
            end
            E_ID0: begin
               lo_ff    <= ev_rd_ff;
               state_ff <= E_ID1;
            end
            E_ID1: begin
               id_ff    <= {ev_rd_ff, lo_ff};
               state_ff <= E_CNT;
            end
            E_CNT: begin
               cnt_ff   <= ev_rd_ff;
               j_ff     <= 8'd0;
               prior_ff <= 11'd1;
               state_ff <= E_DUP;
            end
            E_DUP: begin
               if (j_ff == i_ff) begin
                  if (at_step > {1'b0, len_ff}) begin
                     k_ff     <= '0;
                     state_ff <= E_COPY_RD;
                  end else begin
                     at_ff    <= at_step[erc_pkg::CW-1:0];
                     i_ff     <= i_ff + 8'd1;
                     state_ff <= E_REC;
                  end
               end else begin
                  state_ff <= E_D0;
               end
            end
            E_D0: begin
               lo_ff    <= ev_rd_ff;
               state_ff <= E_D1;
            end
            E_D1: begin
               if ({ev_rd_ff, lo_ff} == id_ff) begin
                  k_ff     <= '0;
                  state_ff <= E_COPY_RD;
               end else begin
                  state_ff <= E_D2;
               end
            end
            E_D2: begin
               prior_ff <= prior_step[erc_pkg::CW-1:0];
               j_ff     <= j_ff + 8'd1;
               state_ff <= E_DUP;
            end
            E_BREC: begin
               k_ff     <= '0;
               state_ff <= (i_ff == count_ff) ? E_PLEN : E_B0;
            end
            E_B0: begin
               lo_ff    <= ev_rd_ff;
               state_ff <= E_B1;
            end
            E_B1: begin
               id_ff    <= {ev_rd_ff, lo_ff};
               state_ff <= E_B2;
            end
            E_B2: begin
               cnt_ff   <= ev_rd_ff;
               cidx_ff  <= out_ff[erc_pkg::AW-1:0] + 10'd2;
               out_ff   <= out_ff + 11'd3;
               at_ff    <= at_ff + 11'd3;
               j_ff     <= 8'd0;
               kept_ff  <= 8'd0;
               state_ff <= E_BCODE;
            end
            E_BCODE: begin
               if (j_ff == cnt_ff) begin
                  i_ff     <= i_ff + 8'd1;
                  state_ff <= E_BREC;
               end else begin
                  state_ff <= E_C0;
               end
            end
            E_C0: begin
               lo_ff    <= ev_rd_ff;
               state_ff <= E_C1;
            end
            E_C1: begin
               hi_ff <= ev_rd_ff;
               if (drop) begin
                  at_ff    <= at_ff + 11'd2;
                  j_ff     <= j_ff + 8'd1;
                  state_ff <= E_BCODE;
               end else begin
                  state_ff <= E_C2;
               end
            end
            E_C2: begin
               out_ff   <= out_ff + 11'd2;
               kept_ff  <= kept_ff + 8'd1;
               at_ff    <= at_ff + 11'd2;
               j_ff     <= j_ff + 8'd1;
               state_ff <= E_BCODE;
            end
            E_PLEN: begin
               k_ff <= k_ff + 11'd1;
               if (k_ff[1:0] == 2'd3) begin
                  state_ff <= E_DONE;
               end
            end
            E_DONE: begin
               state_ff <= E_IDLE;
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   // Completion report.
   assign sts.done      = (state_ff == E_DONE);
   assign sts.rewritten = filt_ff;
   assign sts.length    = filt_ff ? out_ff : n_ff;

endmodule

// ===== design/event_record_code_filter_core.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  operation, data_byte, end_of_event, now_seconds
// rsp      out        rsp_valid / rsp_stall  out_byte, out_last, out_valid, rewritten, overflow
// csr      in         csr_wr_en              csr_wr_data (lease_until)
//
// A pull's item passes through the result store read register and pull_wait_ff into the
// output register, and the next pull waits until that item is taken.
// The final push starts the engine: a pass-through copy reads and writes each byte in
// turn; a filtered event takes the record walk (each record plus a duplicate scan of
// its earlier records), a header copy, then each record with its codes and the
// length field, all in series because the event store has a single read port.
// Reset is synchronous and clears control state only; the stores are not cleared.
// No item is taken while the engine runs, and a pull waits while a result item stalls.
module event_record_code_filter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_event,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic        rsp_out_valid,
   output logic        rsp_rewritten,
   output logic        rsp_overflow,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   erc_pkg::erc_cmd_type cmd;
   erc_pkg::erc_sts_type sts;
   logic [7:0] pull_data;

   logic [31:0] lease_until_ff;
   logic [erc_pkg::CW-1:0] load_count_ff, load_count_in, n_pend_ff, n_final;
   logic [erc_pkg::CW-1:0] read_pointer_ff, result_length_ff, rp_p1;
   logic [7:0]  hdr_ff [erc_pkg::HDR_BYTES];
   logic        pend_ff, proc_ff, ovf_pend_ff, lease_ok_ff;
   logic        result_ready_ff, rewritten_flag_ff, overflow_flag_ff;
   logic        pull_wait_ff, hit_ff, last_ff;
   logic        rsp_valid_ff, rsp_last_ff, rsp_ovalid_ff, rsp_rewritten_ff, rsp_overflow_ff;
   logic [7:0]  rsp_byte_ff;

   logic        push_acc, pull_acc, full, hit, lease_ok, hdr_ok;
   logic [31:0] hdr_type, hdr_len, lease_diff;
   logic [15:0] hdr_target;

   // Handshake.
   assign req_stall = pend_ff | proc_ff | pull_wait_ff |
                      ((req_operation == erc_pkg::OP_PULL) & rsp_valid_ff);
   assign push_acc  = req_valid & !req_stall & (req_operation == erc_pkg::OP_PUSH);
   assign pull_acc  = req_valid & !req_stall & (req_operation == erc_pkg::OP_PULL);

   // Load counter saturates one past the store depth to mark an overflow.
   assign full    = load_count_ff[erc_pkg::CW-1];
   assign n_final = full ? erc_pkg::CW'(erc_pkg::STORE_DEPTH) : load_count_ff + 11'd1;
   always_comb begin
      load_count_in = load_count_ff;
      if (push_acc) begin
         if (req_end_of_event) begin
            load_count_in = '0;
         end else if (full) begin
            load_count_in = erc_pkg::CW'(erc_pkg::STORE_DEPTH + 1);
         end else begin
            load_count_in = load_count_ff + 11'd1;
         end
      end
   end

   // Lease window, sampled with the final byte.
   assign lease_diff = lease_until_ff - req_now_seconds;
   assign lease_ok   = (lease_until_ff != 32'd0) && (lease_until_ff > req_now_seconds) &&
                       (lease_diff <= erc_pkg::LEASE_AHEAD);

   // Header checks, evaluated in the cycle after the final byte is accepted.
   assign hdr_type   = {hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0]};
   assign hdr_target = {hdr_ff[5], hdr_ff[4]};
   assign hdr_len    = {hdr_ff[15], hdr_ff[14], hdr_ff[13], hdr_ff[12]};
   assign hdr_ok = (n_pend_ff >= erc_pkg::CW'(erc_pkg::HDR_LEN)) &&
                   (hdr_type == erc_pkg::EVENT_TYPE) &&
                   (hdr_target == erc_pkg::HOST_TARGET) &&
                   (hdr_len != 32'd0) &&
                   (hdr_len <= 32'(erc_pkg::MAX_PAYLOAD)) &&
                   (hdr_len == {21'd0, n_pend_ff - erc_pkg::CW'(erc_pkg::HDR_LEN)});

   assign rp_p1 = read_pointer_ff + 11'd1;
   assign hit   = result_ready_ff && (read_pointer_ff < result_length_ff);

   // Engine requests.
   assign cmd.push_we    = push_acc & !full;
   assign cmd.push_addr  = load_count_ff[erc_pkg::AW-1:0];
   assign cmd.push_data  = req_data_byte;
   assign cmd.start      = pend_ff;
   assign cmd.try_filter = !ovf_pend_ff & lease_ok_ff & hdr_ok;
   assign cmd.n          = n_pend_ff;
   assign cmd.len        = hdr_len[erc_pkg::CW-1:0];
   assign cmd.count      = hdr_ff[erc_pkg::HDR_LEN];
   assign cmd.pull_addr  = read_pointer_ff[erc_pkg::AW-1:0];

   erc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .pull_data (pull_data)
   );

   // Header capture as bytes are loaded.
   always_ff @(posedge clock) begin
      if (push_acc && (load_count_ff < erc_pkg::CW'(erc_pkg::HDR_BYTES))) begin
         hdr_ff[load_count_ff[4:0]] <= req_data_byte;
      end
   end

   // Configuration, load and event control.
   always_ff @(posedge clock) begin
      if (reset) begin
         lease_until_ff <= 32'd0;
         load_count_ff  <= '0;
         pend_ff        <= 1'b0;
         proc_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lease_until_ff <= csr_wr_data;
         end
         load_count_ff <= load_count_in;
         pend_ff       <= push_acc & req_end_of_event;
         if (push_acc && req_end_of_event) begin
            proc_ff     <= 1'b1;
            n_pend_ff   <= n_final;
            ovf_pend_ff <= full;
            lease_ok_ff <= lease_ok;
         end else if (sts.done) begin
            proc_ff <= 1'b0;
         end
      end
   end

   // Result bookkeeping and pulls.
   always_ff @(posedge clock) begin
      if (reset) begin
         result_ready_ff   <= 1'b0;
         read_pointer_ff   <= '0;
         result_length_ff  <= '0;
         rewritten_flag_ff <= 1'b0;
         overflow_flag_ff  <= 1'b0;
         pull_wait_ff      <= 1'b0;
      end else begin
         pull_wait_ff <= pull_acc;
         if (sts.done) begin
            result_ready_ff   <= 1'b1;
            read_pointer_ff   <= '0;
            result_length_ff  <= sts.length;
            rewritten_flag_ff <= sts.rewritten;
            overflow_flag_ff  <= ovf_pend_ff;
         end else if (pull_acc) begin
            hit_ff  <= hit;
            last_ff <= (rp_p1 == result_length_ff);
            if (hit) begin
               read_pointer_ff <= rp_p1;
               if (rp_p1 >= result_length_ff) begin
                  result_ready_ff <= 1'b0;
               end
            end
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pull_wait_ff) begin
         rsp_valid_ff     <= 1'b1;
         rsp_byte_ff      <= hit_ff ? pull_data : 8'd0;
         rsp_last_ff      <= hit_ff & last_ff;
         rsp_ovalid_ff    <= hit_ff;
         rsp_rewritten_ff <= hit_ff & rewritten_flag_ff;
         rsp_overflow_ff  <= hit_ff & overflow_flag_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_out_valid = rsp_ovalid_ff;
   assign rsp_rewritten = rsp_rewritten_ff;
   assign rsp_overflow  = rsp_overflow_ff;

   // Checks.
   a_pull_gives_item: assert property (@(posedge clock) disable iff (reset)
      pull_acc |-> ##2 rsp_valid_ff) else $error("pull produced no item");
   a_pointer_in_range: assert property (@(posedge clock) disable iff (reset)
      result_ready_ff |-> (read_pointer_ff < result_length_ff))
      else $error("read pointer past result length");
   a_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> proc_ff) else $error("engine finished without an event");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= erc_pkg::CW'(erc_pkg::STORE_DEPTH + 1))
      else $error("load count out of range");

endmodule
